FILE: design/s8cpu_pkg.sv
package s8cpu_pkg;

   localparam int RegCount = 6;
   localparam int PcWidth = 9;
   localparam int DataWidth = 8;

   localparam logic [PcWidth-1:0] MaxLength = PcWidth'(256);

   // Sticky run status as reported on the result channel.
   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_HALT = 2'd1;
   localparam logic [1:0] ST_FAULT = 2'd2;

   typedef logic [RegCount-1:0][DataWidth-1:0] reg_file_type;

   typedef struct packed {
      logic [PcWidth-1:0] pc;
      reg_file_type regs;
      logic [1:0] status;
   } arch_state_type;

endpackage

FILE: design/s8cpu_exec.sv
module s8cpu_exec (
   input s8cpu_pkg::arch_state_type cur_state,
   input logic [8:0] length,
   input logic [7:0] instruction,
   input logic [7:0] in_value,
   output s8cpu_pkg::arch_state_type new_state,
   output logic out_valid,
   output logic [7:0] out_value
);
   import s8cpu_pkg::*;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_ALU = 2'd1;
   localparam logic [1:0] OP_COPY = 2'd2;
   localparam logic [1:0] OP_JUMP = 2'd3;

   localparam logic [2:0] ALU_OR = 3'd0;
   localparam logic [2:0] ALU_NAND = 3'd1;
   localparam logic [2:0] ALU_NOR = 3'd2;
   localparam logic [2:0] ALU_AND = 3'd3;
   localparam logic [2:0] ALU_ADD = 3'd4;
   localparam logic [2:0] ALU_SUB = 3'd5;

   localparam logic [2:0] CND_NEVER = 3'd0;
   localparam logic [2:0] CND_EQZ = 3'd1;
   localparam logic [2:0] CND_LTZ = 3'd2;
   localparam logic [2:0] CND_LEZ = 3'd3;
   localparam logic [2:0] CND_ALWAYS = 3'd4;
   localparam logic [2:0] CND_NEZ = 3'd5;
   localparam logic [2:0] CND_GEZ = 3'd6;
   localparam logic [2:0] CND_GTZ = 3'd7;

   localparam logic [2:0] SEL_PORT = 3'd6;
   localparam logic [2:0] SEL_FAULT = 3'd7;
   localparam logic [7:0] HALT_CODE = 8'hFF;

   logic [8:0] eff_len;
   logic [1:0] opcode;
   logic [2:0] src;
   logic [2:0] low;
   logic [8:0] next;
   logic [1:0] status;
   logic [7:0] r1;
   logic [7:0] r2;
   logic [7:0] r3;
   logic [7:0] alu_res;
   logic alu_wr;
   logic neg;
   logic zero;
   logic taken;
   logic [7:0] copy_val;

   assign eff_len = (length > MaxLength) ? MaxLength : length;
   assign opcode = instruction[7:6];
   assign src = instruction[5:3];
   assign low = instruction[2:0];
   assign r1 = cur_state.regs[1];
   assign r2 = cur_state.regs[2];
   assign r3 = cur_state.regs[3];
   assign neg = r3[7];
   assign zero = (r3 == 8'd0);
   assign copy_val = (src == SEL_PORT) ? in_value : cur_state.regs[src];

   always_comb begin
      alu_wr = 1'b1;
      case (low)
         ALU_OR: alu_res = r1 | r2;
         ALU_NAND: alu_res = ~(r1 & r2);
         ALU_NOR: alu_res = ~(r1 | r2);
         ALU_AND: alu_res = r1 & r2;
         ALU_ADD: alu_res = r1 + r2;
         ALU_SUB: alu_res = r1 - r2;
         default: begin
            alu_wr = 1'b0;
            alu_res = 8'd0;
         end
      endcase
   end

   always_comb begin
      case (low)
         CND_NEVER: taken = 1'b0;
         CND_EQZ: taken = zero;
         CND_LTZ: taken = neg;
         CND_LEZ: taken = neg | zero;
         CND_ALWAYS: taken = 1'b1;
         CND_NEZ: taken = ~zero;
         CND_GEZ: taken = ~neg;
         CND_GTZ: taken = ~neg & ~zero;
         default: taken = 1'b0;
      endcase
   end

   always_comb begin
      new_state = cur_state;
      out_valid = 1'b0;
      out_value = 8'd0;
      status = cur_state.status;
      next = cur_state.pc + 9'd1;

      // A pc that is already out of range stops the machine before execution.
      if (status == ST_RUN && cur_state.pc >= eff_len) begin
         status = ST_HALT;
      end

      if (status == ST_RUN) begin
         if (instruction == HALT_CODE) begin
            status = ST_HALT;
            next = cur_state.pc;
         end else begin
            case (opcode)
               OP_LOAD: new_state.regs[0] = instruction;
               OP_ALU: begin
                  if (alu_wr) begin
                     new_state.regs[3] = alu_res;
                  end
               end
               OP_COPY: begin
                  if (src == SEL_FAULT || low == SEL_FAULT) begin
                     status = ST_FAULT;
                     next = cur_state.pc;
                  end else if (low == SEL_PORT) begin
                     out_valid = 1'b1;
                     out_value = copy_val;
                  end else begin
                     new_state.regs[low] = copy_val;
                  end
               end
               OP_JUMP: begin
                  if (taken) begin
                     next = {1'b0, cur_state.regs[0]};
                  end
               end
               default: next = cur_state.pc;
            endcase
         end
         if (status == ST_RUN && next >= eff_len) begin
            status = ST_HALT;
         end
         new_state.pc = next;
      end
      new_state.status = status;
   end

endmodule

FILE: design/simple_8bit_cpu_step_unit.sv
// One instruction of a small 8-bit register machine per item. An accepted
// item is held in an input register, then a single pass of logic
// executes it against the pc and the six registers and loads the result
// register; a new item can be taken every cycle while rsp_stall does not hold
// the result register, so the sustained rate is one item per clock.
// The pc and register feedback through the execute logic is the loop that
// sets this rate. Once rsp_status reports halted or fault, every later item
// repeats the pc and the status until reset. csr_wr_data sets the program
// length (values above 256 act as 256) and is to be written only while the
// block is idle; the block itself does not enforce this.
module simple_8bit_cpu_step_unit (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_instruction,
   input logic [7:0] req_in_value,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [8:0] rsp_next_pc,
   output logic rsp_out_valid,
   output logic [7:0] rsp_out_value,
   output logic [1:0] rsp_status,
   input logic csr_wr_en,
   input logic [8:0] csr_wr_data
);
   import s8cpu_pkg::*;

   logic in_valid_ff;
   logic in_valid_in;
   logic [7:0] instr_ff;
   logic [7:0] in_value_ff;
   logic out_valid_ff;
   logic out_valid_in;
   logic [8:0] length_ff;
   arch_state_type st_ff;
   arch_state_type st_in;
   logic [8:0] next_pc_ff;
   logic port_valid_ff;
   logic [7:0] port_value_ff;
   logic [1:0] status_ff;
   logic port_valid;
   logic [7:0] port_value;
   logic accept;
   logic exec_fire;

   s8cpu_exec u_exec (
      .cur_state (st_ff),
      .length (length_ff),
      .instruction (instr_ff),
      .in_value (in_value_ff),
      .new_state (st_in),
      .out_valid (port_valid),
      .out_value (port_value)
   );

   // The input register can hand its item on whenever the result register is
   // empty or being drained this cycle.
   assign exec_fire = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !exec_fire;
   assign accept = req_valid && !req_stall;

   assign in_valid_in = accept || (in_valid_ff && !exec_fire);
   assign out_valid_in = exec_fire || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         length_ff <= MaxLength;
         st_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            length_ff <= csr_wr_data;
         end
         if (exec_fire) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         instr_ff <= req_instruction;
         in_value_ff <= req_in_value;
      end
      if (exec_fire) begin
         next_pc_ff <= st_in.pc;
         port_valid_ff <= port_valid;
         port_value_ff <= port_value;
         status_ff <= st_in.status;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_next_pc = next_pc_ff;
   assign rsp_out_valid = port_valid_ff;
   assign rsp_out_value = port_value_ff;
   assign rsp_status = status_ff;

   a_sticky_stop: assert property (@(posedge clock) disable iff (reset)
      (st_ff.status != ST_RUN) |=> (st_ff.status == $past(st_ff.status)
         && st_ff.pc == $past(st_ff.pc)))
      else $error("stopped machine changed its pc or status");

   a_port_no_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_valid) |-> (rsp_status != ST_FAULT))
      else $error("output port written by a faulting item");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> (rsp_valid && rsp_next_pc == st_ff.pc
         && rsp_status == st_ff.status))
      else $error("result register disagrees with machine state");

endmodule
